// File: rtl/btpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package btpc_pkg;

   localparam int RAW_W     = 20;
   localparam int FINE_W    = 22;
   localparam int DIV_N_W   = 64;
   localparam int DIV_D_W   = 31;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAL_T1       = 3'd0,
      CSR_CAL_T2       = 3'd1,
      CSR_CAL_T3       = 3'd2,
      CSR_CAL_P1       = 3'd3,
      CSR_CAL_P2_TO_P5 = 3'd4,
      CSR_CAL_P6_TO_P9 = 3'd5
   } csr_idx_type;

   // calibration words as held in the register file
   typedef struct packed {
      logic [15:0] t1;
      logic [15:0] t2;
      logic [15:0] t3;
      logic [15:0] p1;
      logic [63:0] p2_5;
      logic [63:0] p6_9;
   } cal_type;

   // side information that rides along with the divider
   typedef struct packed {
      logic signed [FINE_W-1:0] fine;
      logic                     neg;
      logic                     zero;
   } div_tag_type;

endpackage
`default_nettype wire

// File: rtl/btpc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module btpc_front (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               en,
   input  wire btpc_pkg::cal_type                  cal,
   input  wire logic                               in_valid,
   input  wire logic [btpc_pkg::RAW_W-1:0]         raw_t,
   input  wire logic [btpc_pkg::RAW_W-1:0]         raw_p,
   output logic                                    out_valid,
   output logic [btpc_pkg::DIV_N_W-1:0]            out_num,
   output logic [btpc_pkg::DIV_D_W-1:0]            out_den,
   output btpc_pkg::div_tag_type                   out_tag
);

   localparam logic signed [53:0] P_BIAS = 54'sd1 <<< 47;

   logic [9:0] vld_ff;

   logic signed [18:0] a1_ff, a1_in;
   logic signed [17:0] b1_ff, b1_in;
   logic        [20:0] ap1_ff, ap1_in, ap2_ff, ap3_ff, ap4_ff, ap5_ff, ap6_ff, ap7_ff;

   logic signed [34:0] at2;
   logic signed [35:0] bb;
   logic signed [20:0] tv1_2_ff, tv1_2_in;
   logic signed [19:0] bbs_2_ff, bbs_2_in;

   logic signed [35:0] bt3;
   logic signed [17:0] tv2;
   logic signed [21:0] tv1x, tv2x;
   logic signed [21:0] fine3_ff, fine3_in, fine4_ff, fine5_ff, fine6_ff, fine7_ff;
   logic signed [21:0] fine8_ff, fine9_ff;

   logic signed [22:0] v1x, v1_4_ff, v1_4_in;

   logic signed [45:0] v1sq_5_ff, v1sq_5_in;
   logic signed [38:0] v1p5_5_ff, v1p5_5_in, v1p2_5_ff, v1p2_5_in, v1p5_6_ff, v1p2_6_ff;

   logic signed [61:0] t6_6_ff, t6_6_in, t3_6_ff, t3_6_in;

   logic signed [63:0] t6x, p5x, p4x, v2_7_ff, v2_7_in;
   logic signed [53:0] t3s, p2s, v1b_7_ff, v1b_7_in;

   logic signed [70:0] dv;
   logic signed [30:0] dsr_8_ff, dsr_8_in, dsr_9_ff;
   logic        [63:0] x_8_ff, x_8_in, dnd_9_ff, dnd_9_in;

   logic [btpc_pkg::DIV_N_W-1:0] num_ff, num_in;
   logic [btpc_pkg::DIV_D_W-1:0] den_ff, den_in;
   btpc_pkg::div_tag_type        tag_ff, tag_in;

   always_comb begin
      // temperature path
      a1_in    = $signed({2'b00, raw_t[19:3]}) - $signed({2'b00, cal.t1, 1'b0});
      b1_in    = $signed({2'b00, raw_t[19:4]}) - $signed({2'b00, cal.t1});
      ap1_in   = 21'd1048576 - {1'b0, raw_p};
      at2      = a1_ff * $signed(cal.t2);
      bb       = b1_ff * b1_ff;
      tv1_2_in = at2[31:11];
      bbs_2_in = bb[31:12];
      bt3      = bbs_2_ff * $signed(cal.t3);
      tv2      = bt3[31:14];
      tv1x     = tv1_2_ff;
      tv2x     = tv2;
      fine3_in = tv1x + tv2x;
      // pressure coefficients
      v1x       = fine3_ff;
      v1_4_in   = v1x - 23'sd128000;
      v1sq_5_in = v1_4_ff * v1_4_ff;
      v1p5_5_in = v1_4_ff * $signed(cal.p2_5[63:48]);
      v1p2_5_in = v1_4_ff * $signed(cal.p2_5[15:0]);
      t6_6_in   = v1sq_5_ff * $signed(cal.p6_9[15:0]);
      t3_6_in   = v1sq_5_ff * $signed(cal.p2_5[31:16]);
      t6x       = t6_6_ff;
      p5x       = v1p5_6_ff;
      p4x       = $signed(cal.p2_5[47:32]);
      v2_7_in   = t6x + (p5x <<< 17) + (p4x <<< 35);
      t3s       = t3_6_ff[61:8];
      p2s       = $signed({v1p2_6_ff, 12'd0});
      v1b_7_in  = t3s + p2s + P_BIAS;
      dv        = v1b_7_ff * $signed({1'b0, cal.p1});
      dsr_8_in  = dv[63:33];
      x_8_in    = {12'd0, ap7_ff, 31'd0} - v2_7_ff;
      dnd_9_in  = x_8_ff * 64'd3125;
      // split into magnitudes and quotient sign
      num_in      = dnd_9_ff[63] ? (64'd0 - dnd_9_ff) : dnd_9_ff;
      den_in      = dsr_9_ff[30] ? (31'd0 - dsr_9_ff) : dsr_9_ff;
      tag_in.fine = fine9_ff;
      tag_in.neg  = dnd_9_ff[63] ^ dsr_9_ff[30];
      tag_in.zero = (dsr_9_ff == 31'sd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[8:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff     <= a1_in;
         b1_ff     <= b1_in;
         ap1_ff    <= ap1_in;
         tv1_2_ff  <= tv1_2_in;
         bbs_2_ff  <= bbs_2_in;
         ap2_ff    <= ap1_ff;
         fine3_ff  <= fine3_in;
         ap3_ff    <= ap2_ff;
         v1_4_ff   <= v1_4_in;
         fine4_ff  <= fine3_ff;
         ap4_ff    <= ap3_ff;
         v1sq_5_ff <= v1sq_5_in;
         v1p5_5_ff <= v1p5_5_in;
         v1p2_5_ff <= v1p2_5_in;
         fine5_ff  <= fine4_ff;
         ap5_ff    <= ap4_ff;
         t6_6_ff   <= t6_6_in;
         t3_6_ff   <= t3_6_in;
         v1p5_6_ff <= v1p5_5_ff;
         v1p2_6_ff <= v1p2_5_ff;
         fine6_ff  <= fine5_ff;
         ap6_ff    <= ap5_ff;
         v2_7_ff   <= v2_7_in;
         v1b_7_ff  <= v1b_7_in;
         fine7_ff  <= fine6_ff;
         ap7_ff    <= ap6_ff;
         dsr_8_ff  <= dsr_8_in;
         x_8_ff    <= x_8_in;
         fine8_ff  <= fine7_ff;
         dnd_9_ff  <= dnd_9_in;
         dsr_9_ff  <= dsr_8_ff;
         fine9_ff  <= fine8_ff;
         num_ff    <= num_in;
         den_ff    <= den_in;
         tag_ff    <= tag_in;
      end
   end

   assign out_valid = vld_ff[9];
   assign out_num   = num_ff;
   assign out_den   = den_ff;
   assign out_tag   = tag_ff;

endmodule
`default_nettype wire

// File: rtl/btpc_div.sv
`timescale 1ns / 1ps
`default_nettype none
module btpc_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              en,
   input  wire logic                              in_valid,
   input  wire logic [btpc_pkg::DIV_N_W-1:0]      in_num,
   input  wire logic [btpc_pkg::DIV_D_W-1:0]      in_den,
   input  wire btpc_pkg::div_tag_type             in_tag,
   output logic                                   out_valid,
   output logic [btpc_pkg::DIV_N_W-1:0]           out_quo,
   output btpc_pkg::div_tag_type                  out_tag
);

   localparam int NW = btpc_pkg::DIV_N_W;
   localparam int DW = btpc_pkg::DIV_D_W;

   logic                  vld_ff [NW];
   logic [DW-1:0]         rem_ff [NW];
   logic [NW-1:0]         num_ff [NW];
   logic [DW-1:0]         den_ff [NW];
   btpc_pkg::div_tag_type tag_ff [NW];

   // one quotient bit per stage, numerator bits shift out the top as
   // quotient bits shift in at the bottom
   for (genvar k = 0; k < NW; k++) begin : g_stage
      logic                  vld_prev;
      logic [DW-1:0]         rem_prev;
      logic [NW-1:0]         num_prev;
      logic [DW-1:0]         den_prev;
      btpc_pkg::div_tag_type tag_prev;
      logic [DW:0]           trial;
      logic [DW:0]           diff;
      logic                  ge;
      logic [DW-1:0]         rem_in;
      logic [NW-1:0]         num_in;

      if (k == 0) begin : g_first
         assign vld_prev = in_valid;
         assign rem_prev = '0;
         assign num_prev = in_num;
         assign den_prev = in_den;
         assign tag_prev = in_tag;
      end else begin : g_next
         assign vld_prev = vld_ff[k-1];
         assign rem_prev = rem_ff[k-1];
         assign num_prev = num_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign tag_prev = tag_ff[k-1];
      end

      always_comb begin
         trial  = {rem_prev, num_prev[NW-1]};
         diff   = trial - {1'b0, den_prev};
         ge     = (trial >= {1'b0, den_prev});
         rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
         num_in = {num_prev[NW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            num_ff[k] <= num_in;
            den_ff[k] <= den_prev;
            tag_ff[k] <= tag_prev;
         end
      end
   end

   assign out_valid = vld_ff[NW-1];
   assign out_quo   = num_ff[NW-1];
   assign out_tag   = tag_ff[NW-1];

endmodule
`default_nettype wire

// File: rtl/btpc_back.sv
`timescale 1ns / 1ps
`default_nettype none
module btpc_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire btpc_pkg::cal_type             cal,
   input  wire logic                          in_valid,
   input  wire logic [btpc_pkg::DIV_N_W-1:0]  in_quo,
   input  wire btpc_pkg::div_tag_type         in_tag,
   output logic                               out_valid,
   output logic [15:0]                        out_temp,
   output logic [31:0]                        out_pres,
   output logic                               out_status
);

   logic [5:0] vld_ff;

   logic signed [24:0] f25, f5;
   logic signed [16:0] tcw;
   logic        [15:0] tc1_in, tc1_ff, tc2_ff, tc3_ff, tc4_ff, tc5_ff;
   logic               z1_ff, z2_ff, z3_ff, z4_ff, z5_ff;
   logic        [63:0] q1_in, q1_ff, q2_ff, q3_ff, q4_ff;

   logic        [63:0] qs;
   logic        [63:0] lo_2_in, lo_2_ff;
   logic        [31:0] cr_2_in, cr_2_ff;
   logic signed [79:0] m8w, m9w;
   logic        [63:0] m8_2_ff;

   logic        [63:0] sq_3_in, sq_3_ff, w2_3_in, w2_3_ff, w2_4_ff;
   logic        [63:0] m9_4_ff;
   logic        [63:0] w1, s_5_in, s_5_ff;
   logic        [63:0] r;
   logic        [31:0] pres_in, pres_ff;
   logic        [15:0] temp_ff;
   logic               status_ff;

   always_comb begin
      // temperature: (fine*5 + 128) >> 8, clamp to 16 bits
      f25    = in_tag.fine;
      f5     = f25 + (f25 <<< 2) + 25'sd128;
      tcw    = f5[24:8];
      tc1_in = (tcw[16] != tcw[15]) ? (tcw[16] ? 16'h8000 : 16'h7FFF) : tcw[15:0];
      q1_in  = in_tag.neg ? (64'd0 - in_quo) : in_quo;
      // q*q modulo 2^64 from two 32x32 products
      qs      = {{13{q1_ff[63]}}, q1_ff[63:13]};
      lo_2_in = qs[31:0] * qs[31:0];
      cr_2_in = qs[31:0] * qs[63:32];
      m8w     = $signed(q1_ff) * $signed(cal.p6_9[47:32]);
      sq_3_in = lo_2_ff + {cr_2_ff[30:0], 1'b0, 32'd0};
      w2_3_in = {{19{m8_2_ff[63]}}, m8_2_ff[63:19]};
      m9w     = $signed(sq_3_ff) * $signed(cal.p6_9[63:48]);
      w1      = {{25{m9_4_ff[63]}}, m9_4_ff[63:25]};
      s_5_in  = q4_ff + w1 + w2_4_ff;
      r       = {{8{s_5_ff[63]}}, s_5_ff[63:8]}
              + {{44{cal.p6_9[31]}}, cal.p6_9[31:16], 4'd0};
      // clamp to 0 .. 2^32-1
      if (r[63]) begin
         pres_in = '0;
      end else if (r[62:32] != '0) begin
         pres_in = '1;
      end else begin
         pres_in = r[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tc1_ff    <= tc1_in;
         z1_ff     <= in_tag.zero;
         q1_ff     <= q1_in;
         lo_2_ff   <= lo_2_in;
         cr_2_ff   <= cr_2_in;
         m8_2_ff   <= m8w[63:0];
         tc2_ff    <= tc1_ff;
         z2_ff     <= z1_ff;
         q2_ff     <= q1_ff;
         sq_3_ff   <= sq_3_in;
         w2_3_ff   <= w2_3_in;
         tc3_ff    <= tc2_ff;
         z3_ff     <= z2_ff;
         q3_ff     <= q2_ff;
         m9_4_ff   <= m9w[63:0];
         w2_4_ff   <= w2_3_ff;
         tc4_ff    <= tc3_ff;
         z4_ff     <= z3_ff;
         q4_ff     <= q3_ff;
         s_5_ff    <= s_5_in;
         tc5_ff    <= tc4_ff;
         z5_ff     <= z4_ff;
         // zero divisor: report status, drop both readings to zero
         pres_ff   <= z5_ff ? 32'd0 : pres_in;
         temp_ff   <= z5_ff ? 16'd0 : tc5_ff;
         status_ff <= z5_ff;
      end
   end

   assign out_valid  = vld_ff[5];
   assign out_temp   = temp_ff;
   assign out_pres   = pres_ff;
   assign out_status = status_ff;

endmodule
`default_nettype wire

// File: rtl/baro_temp_pressure_compensation.sv
`timescale 1ns / 1ps
`default_nettype none
// Barometric temperature and pressure compensation.
//
// req_*: one word per reading pair (raw temperature, raw pressure, 20 bits
//   each). rsp_*: one word per pair, temperature in 0.01 degC (signed 16),
//   pressure in Pa as Q24.8 (unsigned 32), status in tuser (1 = divisor
//   zero, both readings forced to zero).
// csr_*: write index and data for the six calibration registers; always
//   ready, write only while no word is in flight.
// Throughput: one word per clock while req_tready is high. From acceptance
//   on req to rsp_tvalid a word passes ten front stages, the 64-stage
//   divider (one quotient bit per stage), six back stages and the output register.
// Reset clears calibration to zero and empties every stage; no stale word
//   comes out after reset.
// When rsp stalls, the output register holds and one more word lands in a
//   skid register; the pipe then freezes as a whole (req_tready low) until
//   the skid drains, so nothing is dropped or repeated.
module baro_temp_pressure_compensation (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // [19:0] raw_temperature, [39:20] raw_pressure
   input  wire logic [2*btpc_pkg::RAW_W-1:0]         req_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // [15:0] temperature_centideg, [47:16] pressure_q24_8
   output logic [47:0]                               rsp_tdata,
   // [0] status
   output logic                                      rsp_tuser,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [btpc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [63:0]                          csr_data
);

   btpc_pkg::cal_type cal_ff, cal_in;

   logic en;

   logic                             f_valid;
   logic [btpc_pkg::DIV_N_W-1:0]     f_num;
   logic [btpc_pkg::DIV_D_W-1:0]     f_den;
   btpc_pkg::div_tag_type            f_tag;
   logic                             d_valid;
   logic [btpc_pkg::DIV_N_W-1:0]     d_quo;
   btpc_pkg::div_tag_type            d_tag;
   logic                             b_valid;
   logic [15:0]                      b_temp;
   logic [31:0]                      b_pres;
   logic                             b_status;

   logic        out_valid_ff, out_valid_in;
   logic [15:0] out_temp_ff, out_temp_in;
   logic [31:0] out_pres_ff, out_pres_in;
   logic        out_status_ff, out_status_in;
   logic        skid_valid_ff, skid_valid_in;
   logic [15:0] skid_temp_ff;
   logic [31:0] skid_pres_ff;
   logic        skid_status_ff;

   // calibration register file
   always_comb begin
      cal_in = cal_ff;
      if (csr_valid) begin
         case (btpc_pkg::csr_idx_type'(csr_index))
            btpc_pkg::CSR_CAL_T1:       cal_in.t1   = csr_data[15:0];
            btpc_pkg::CSR_CAL_T2:       cal_in.t2   = csr_data[15:0];
            btpc_pkg::CSR_CAL_T3:       cal_in.t3   = csr_data[15:0];
            btpc_pkg::CSR_CAL_P1:       cal_in.p1   = csr_data[15:0];
            btpc_pkg::CSR_CAL_P2_TO_P5: cal_in.p2_5 = csr_data;
            btpc_pkg::CSR_CAL_P6_TO_P9: cal_in.p6_9 = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else begin
         cal_ff <= cal_in;
      end
   end

   assign csr_ready = 1'b1;

   // the whole pipe advances while the skid register is free
   assign en         = !skid_valid_ff;
   assign req_tready = en;

   btpc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cal       (cal_ff),
      .in_valid  (req_tvalid),
      .raw_t     (req_tdata[btpc_pkg::RAW_W-1:0]),
      .raw_p     (req_tdata[2*btpc_pkg::RAW_W-1:btpc_pkg::RAW_W]),
      .out_valid (f_valid),
      .out_num   (f_num),
      .out_den   (f_den),
      .out_tag   (f_tag)
   );

   btpc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_num    (f_num),
      .in_den    (f_den),
      .in_tag    (f_tag),
      .out_valid (d_valid),
      .out_quo   (d_quo),
      .out_tag   (d_tag)
   );

   btpc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .cal        (cal_ff),
      .in_valid   (d_valid),
      .in_quo     (d_quo),
      .in_tag     (d_tag),
      .out_valid  (b_valid),
      .out_temp   (b_temp),
      .out_pres   (b_pres),
      .out_status (b_status)
   );

   // output register with skid: take the skid first, else the pipe's word
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_temp_in   = out_temp_ff;
      out_pres_in   = out_pres_ff;
      out_status_in = out_status_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || rsp_tready) begin
         skid_valid_in = 1'b0;
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_temp_in   = skid_temp_ff;
            out_pres_in   = skid_pres_ff;
            out_status_in = skid_status_ff;
         end else begin
            out_valid_in  = b_valid;
            out_temp_in   = b_temp;
            out_pres_in   = b_pres;
            out_status_in = b_status;
         end
      end else if (en && b_valid) begin
         // output stalled: park the word leaving the pipe
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_temp_ff   <= out_temp_in;
      out_pres_ff   <= out_pres_in;
      out_status_ff <= out_status_in;
      if (en) begin
         skid_temp_ff   <= b_temp;
         skid_pres_ff   <= b_pres;
         skid_status_ff <= b_status;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_pres_ff, out_temp_ff};
   assign rsp_tuser  = out_status_ff;

`ifndef ASSERT_OFF
   a_zero_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 48'd0)
      else $error("zero divisor word carries nonzero readings");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp_tready))
      else $error("skid filled while output was free");

   a_skid_hold: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_tready |=> skid_valid_ff)
      else $error("skid word dropped during stall");

   a_skid_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a word behind an empty output");
`endif

endmodule
`default_nettype wire

// File: tb/baro_temp_pressure_compensation_tb.sv
`timescale 1ns / 1ps
module baro_temp_pressure_compensation_tb;

   localparam int LATENCY = 81;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [39:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [63:0] csr_data = '0;

   baro_temp_pressure_compensation dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   typedef struct packed {
      logic [15:0] temp_cdeg;
      logic [31:0] press_q24_8;
      logic        div_zero;
   } reading_type;

   // calibration shadow of the block's registers
   logic [15:0] sh_t1, sh_t2, sh_t3, sh_p1;
   logic [63:0] sh_p2_5, sh_p6_9;

   reading_type expected_readings[$];
   int mismatches = 0;
   int received = 0;
   bit quiet = 1'b0;     // stretch with no idling on either side

   function automatic logic [63:0] sx16(input logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   function automatic logic [63:0] quotient_trunc(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] ma, mb, q;
      ma = a[63] ? -a : a;
      mb = b[63] ? -b : b;
      q = ma / mb;
      return (a[63] != b[63]) ? -q : q;
   endfunction

   // compensate one reading pair with the current calibration
   function automatic reading_type compensate(input logic [19:0] adc_t, input logic [19:0] adc_p);
      reading_type r;
      logic signed [31:0] a, b, tv1, tv2, t1, t2, t3;
      logic signed [63:0] fine, v1, v2, p, q, w1, w2, tc;
      logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      t1 = {16'd0, sh_t1};
      t2 = {{16{sh_t2[15]}}, sh_t2};
      t3 = {{16{sh_t3[15]}}, sh_t3};
      p1 = {48'd0, sh_p1};
      p2 = sx16(sh_p2_5[15:0]);  p3 = sx16(sh_p2_5[31:16]);
      p4 = sx16(sh_p2_5[47:32]); p5 = sx16(sh_p2_5[63:48]);
      p6 = sx16(sh_p6_9[15:0]);  p7 = sx16(sh_p6_9[31:16]);
      p8 = sx16(sh_p6_9[47:32]); p9 = sx16(sh_p6_9[63:48]);
      a = {15'd0, adc_t[19:3]} - (t1 << 1);
      tv1 = (a * t2) >>> 11;
      b = {16'd0, adc_t[19:4]} - t1;
      tv2 = (((b * b) >>> 12) * t3) >>> 14;
      tv1 = tv1 + tv2;
      fine = {{32{tv1[31]}}, tv1};
      v1 = fine - 64'sd128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) <<< 17);
      v2 = v2 + (p4 <<< 35);
      v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
      v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
      if (v1 == 0) begin
         r = '0;
         r.div_zero = 1'b1;
         return r;
      end
      tc = (fine * 5 + 128) >>> 8;
      if (tc > 32767) tc = 32767;
      if (tc < -32768) tc = -32768;
      p = 64'sd1048576 - {44'd0, adc_p};
      p = quotient_trunc(((p <<< 31) - v2) * 64'sd3125, v1);
      q = p >>> 13;
      w1 = (p9 * q * q) >>> 25;
      w2 = (p8 * p) >>> 19;
      p = ((p + w1 + w2) >>> 8) + (p7 <<< 4);
      r.temp_cdeg = tc[15:0];
      if (p < 0) r.press_q24_8 = '0;
      else if (p > 64'sd4294967295) r.press_q24_8 = '1;
      else r.press_q24_8 = p[31:0];
      r.div_zero = 1'b0;
      return r;
   endfunction

   // write one calibration register while the pipe is empty; the caller drops
   // csr_valid after the last write
   task automatic write_cal(input btpc_pkg::csr_idx_type idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         btpc_pkg::CSR_CAL_T1:       sh_t1 = value[15:0];
         btpc_pkg::CSR_CAL_T2:       sh_t2 = value[15:0];
         btpc_pkg::CSR_CAL_T3:       sh_t3 = value[15:0];
         btpc_pkg::CSR_CAL_P1:       sh_p1 = value[15:0];
         btpc_pkg::CSR_CAL_P2_TO_P5: sh_p2_5 = value;
         default:                    sh_p6_9 = value;
      endcase
   endtask

   task automatic load_cal(input logic [15:0] t1, t2, t3, p1, input logic [63:0] p25, p69);
      write_cal(btpc_pkg::CSR_CAL_T1, {48'd0, t1});
      write_cal(btpc_pkg::CSR_CAL_T2, {48'd0, t2});
      write_cal(btpc_pkg::CSR_CAL_T3, {48'd0, t3});
      write_cal(btpc_pkg::CSR_CAL_P1, {48'd0, p1});
      write_cal(btpc_pkg::CSR_CAL_P2_TO_P5, p25);
      write_cal(btpc_pkg::CSR_CAL_P6_TO_P9, p69);
      csr_valid <= 1'b0;
   endtask

   // send one reading pair, idling beforehand at random
   task automatic send_reading(input logic [19:0] adc_t, input logic [19:0] adc_p,
                               input bit has_want, input reading_type want);
      reading_type pred;
      while (!quiet && $urandom_range(99) < 8) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {adc_p, adc_t};
      do @(posedge clock); while (!req_tready);
      pred = compensate(adc_t, adc_p);
      if (has_want && pred !== want)
         $display("table row disagrees with predictor: %h vs %h", want, pred);
      expected_readings.push_back(has_want ? want : pred);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   // directed rows: no expected reading is typed in; compensate() supplies each
   typedef struct {
      logic [19:0] adc_t;
      logic [19:0] adc_p;
      bit          has_want;
      reading_type want;
   } row_type;

   row_type dir_rows[] = '{
      '{20'h00000, 20'h00000, 1'b0, '{16'd0, 32'd0, 1'b0}},
      '{20'hFFFFF, 20'hFFFFF, 1'b0, '{16'd0, 32'd0, 1'b0}},
      '{20'h80000, 20'h7FFFF, 1'b0, '{16'd0, 32'd0, 1'b0}},
      '{20'h7E3C0, 20'h65A80, 1'b0, '{16'd0, 32'd0, 1'b0}},
      '{20'h00000, 20'hFFFFF, 1'b0, '{16'd0, 32'd0, 1'b0}},
      '{20'hFFFFF, 20'h00000, 1'b0, '{16'd0, 32'd0, 1'b0}},
      '{20'h55555, 20'hAAAAA, 1'b0, '{16'd0, 32'd0, 1'b0}},
      '{20'hAAAAA, 20'h55555, 1'b0, '{16'd0, 32'd0, 1'b0}},
      '{20'h00001, 20'h00001, 1'b0, '{16'd0, 32'd0, 1'b0}}
   };

   // sensor-like calibration with random jitter (style 0), else fully random words
   task automatic load_random_cal(input int style);
      logic [63:0] p25, p69;
      p25 = {$urandom, $urandom};
      p69 = {$urandom, $urandom};
      if (style == 0) begin
         p25 = {16'($urandom_range(0, 400) - 200), 16'($urandom_range(2000, 4000)),
                16'($urandom_range(0, 6000) + 4000) ^ 16'h8000 ^ 16'h8000,
                16'(-$urandom_range(9000, 12000))};
         p69 = {16'($urandom_range(4000, 6000)), 16'(-$urandom_range(10000, 16000)),
                16'($urandom_range(0, 30)), 16'(-$urandom_range(0, 15))};
         load_cal(16'($urandom_range(26000, 29000)), 16'($urandom_range(25000, 28000)),
                  16'($urandom_range(50, 1000)) | 16'(0), 16'($urandom_range(30000, 40000)),
                  p25, p69);
      end else begin
         load_cal(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), p25, p69);
      end
   endtask

   // result side: stall at random, compare with oldest expectation
   always @(posedge clock) begin
      if (!reset) begin
         rsp_tready <= quiet || ($urandom_range(99) >= 8);
         if (rsp_tvalid && rsp_tready) begin
            reading_type got, want;
            got = {rsp_tdata[15:0], rsp_tdata[47:16], rsp_tuser};
            received++;
            if (expected_readings.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected word %h", got);
            end else begin
               want = expected_readings.pop_front();
               if (got.temp_cdeg !== want.temp_cdeg || got.press_q24_8 !== want.press_q24_8
                   || got.div_zero !== want.div_zero) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("word %0d: expected t=%h p=%h s=%b, got t=%h p=%h s=%b",
                              received, want.temp_cdeg, want.press_q24_8, want.div_zero,
                              got.temp_cdeg, got.press_q24_8, got.div_zero);
               end
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      sh_t1 = '0; sh_t2 = '0; sh_t3 = '0; sh_p1 = '0; sh_p2_5 = '0; sh_p6_9 = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset calibration: divisor zero on every word
      send_reading(20'h12345, 20'h6789A, 1'b1, '{16'd0, 32'd0, 1'b1});
      drain();

      // nominal calibration, then directed rows
      load_cal(16'd27504, 16'd26435, 16'hFC18, 16'd36477,
               {16'd140, 16'd2855, 16'hD0D0, 16'hD6D0},
               {16'd6000, 16'hC3F8, 16'd15500, 16'hFFF9});
      foreach (dir_rows[i])
         send_reading(dir_rows[i].adc_t, dir_rows[i].adc_p, dir_rows[i].has_want,
                      dir_rows[i].want);
      drain();

      // extremes of calibration: all ones, sign bits only, p1 zero
      load_cal('1, '1, '1, '1, '1, '1);
      send_reading(20'hFFFFF, 20'h00000, 1'b0, '0);
      send_reading(20'h00000, 20'hFFFFF, 1'b0, '0);
      drain();
      load_cal(16'h8000, 16'h8000, 16'h8000, 16'h8000, {4{16'h8000}}, {4{16'h8000}});
      send_reading(20'h80000, 20'h80000, 1'b0, '0);
      send_reading(20'hFFFFF, 20'hFFFFF, 1'b0, '0);
      drain();
      write_cal(btpc_pkg::CSR_CAL_P1, 64'd0);
      csr_valid <= 1'b0;
      send_reading(20'h7E3C0, 20'h65A80, 1'b1, '{16'd0, 32'd0, 1'b1});
      drain();

      // random phases: mostly realistic calibration, some fully random
      for (int ph = 0; ph < 11; ph++) begin
         load_random_cal((ph % 3 == 2) ? 1 : 0);
         quiet = (ph == 4);
         for (int n = 0; n < 100; n++)
            send_reading(20'($urandom_range(400000, 600000)
                             ^ ($urandom_range(9) == 0 ? $urandom : 0)),
                         20'($urandom), 1'b0, '0);
         quiet = 1'b0;
         drain();
      end

      if (mismatches == 0 && expected_readings.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
